>>> hdl/eimt_pkg.sv
// ----------------------------------------------------------------------------
// eimt_pkg
// Shared types and constants of the expiring interval max table: field
// widths, stream packing offsets, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package eimt_pkg;

	// field widths
	localparam int unsigned POS_W   = 20;
	localparam int unsigned PRICE_W = 30;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned OUT_W   = 31;
	localparam int unsigned SUM_W   = KEY_W + 1;

	// one table word: {valid, expiry, key}
	localparam int unsigned WORD_W  = 1 + POS_W + KEY_W;

	// input tdata: start_pos, end_pos, base_price, position (lowest first)
	localparam int unsigned START_LSB = 0;
	localparam int unsigned END_LSB   = START_LSB + POS_W;
	localparam int unsigned PRICE_LSB = END_LSB + POS_W;
	localparam int unsigned POS_LSB   = PRICE_LSB + PRICE_W;
	localparam int unsigned IN_BITS   = POS_LSB + POS_W;
	localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// output tdata: best_price, none_active, table_full (lowest first)
	localparam int unsigned OUT_BITS   = OUT_W + 2;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

	// item kind carried on tuser
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_TICK,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic take;      // ready for an input transaction
		logic clear_wr;  // sweep the table invalid
		logic issue;     // issue a table read at the scan counter
		logic add_run;   // look for a free slot in the read data
		logic tick_run;  // evict and track the maximum in the read data
		logic out_load;  // load the output register
	} ctl_cmd_t;

	typedef struct packed {
		logic cnt_end;   // scan counter reached the capacity
		logic pipe_busy; // a read is in flight
		logic free_hit;  // read data shows a free slot during an add
		logic full;      // every slot is taken
		logic out_free;  // the output register can take a result
	} dp_stat_t;

endpackage

>>> hdl/expiring_interval_max_table.sv
// Tick: reads every slot of the memory, one read per cycle, before the result
//   is loaded.
// Add: reads the slots from the lowest possibly free slot up to the first free
//   one; a dropped add (full table) goes straight to the result.
// Transactions: one in flight; the next is accepted after the result loads.
// Reset: a clearing pass writes every slot invalid; no input is taken until it ends.
// ----------------------------------------------------------------------------
// expiring_interval_max_table
// Table of active offers with expiry. An add stores key = base_price - start
// and expiry = end in the lowest free slot. A tick evicts entries whose expiry
// lies before the position and returns the largest key plus the position.
// ----------------------------------------------------------------------------
module expiring_interval_max_table #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side: one transaction is one add or one tick
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// start_pos[19:0], end_pos[39:20], base_price[69:40], position[89:70], zero pad
	input  logic [eimt_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind[0]: 0 add, 1 tick
	input  logic                            s_tuser,
	// master side: exactly one result transaction per input transaction
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// best_price[30:0], none_active[31], table_full[32], zero pad
	output logic [eimt_pkg::OUT_DATA_W-1:0] m_tdata
);

	// command and status bundles between controller and datapath
	eimt_pkg::ctl_cmd_t cmd;
	eimt_pkg::dp_stat_t stat;

	// Controller: clearing pass after reset, then idle until an item arrives.
	// An add on a table that is not full scans forward from the free-slot hint
	// until it meets a free slot; a tick scans every slot once, evicting and
	// tracking the maximum key. The result then waits in the output register
	// while the next item is accepted.
	eimt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: slot memory with one write and one registered read per cycle,
	// occupancy count, hint of the lowest possibly free slot, running maximum
	// and the saturating sum into the output register.
	eimt_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ready only while the controller waits for a new transaction
	assign s_tready = cmd.take;

endmodule

>>> hdl/eimt_ctrl.sv
// ----------------------------------------------------------------------------
// eimt_ctrl
// Controller of the expiring interval max table: clearing pass, add scan,
// tick scan and result hand-off.
// ----------------------------------------------------------------------------
module eimt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	input  eimt_pkg::dp_stat_t  stat,
	output eimt_pkg::ctl_cmd_t  cmd
);

	eimt_pkg::state_t state_q;
	eimt_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eimt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			eimt_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.cnt_end) begin
					state_nxt = eimt_pkg::ST_IDLE;
				end
			end
			eimt_pkg::ST_IDLE: begin
				cmd.take = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == eimt_pkg::KIND_TICK) begin
						state_nxt = eimt_pkg::ST_TICK;
					end else if (stat.full) begin
						state_nxt = eimt_pkg::ST_RESULT;
					end else begin
						state_nxt = eimt_pkg::ST_ADD;
					end
				end
			end
			eimt_pkg::ST_ADD: begin
				cmd.issue   = 1'b1;
				cmd.add_run = 1'b1;
				if (stat.free_hit) begin
					state_nxt = eimt_pkg::ST_RESULT;
				end
			end
			eimt_pkg::ST_TICK: begin
				cmd.issue    = 1'b1;
				cmd.tick_run = 1'b1;
				if (stat.cnt_end && !stat.pipe_busy) begin
					state_nxt = eimt_pkg::ST_RESULT;
				end
			end
			eimt_pkg::ST_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = eimt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = eimt_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

>>> hdl/eimt_dpath.sv
// ----------------------------------------------------------------------------
// eimt_dpath
// Datapath of the expiring interval max table: slot memory, scan counter,
// read stage, running maximum, occupancy and free-slot hint, output register.
// ----------------------------------------------------------------------------
module eimt_dpath #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  eimt_pkg::ctl_cmd_t                   cmd,
	output eimt_pkg::dp_stat_t                   stat,
	input  logic                                 s_tvalid,
	input  logic [eimt_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [eimt_pkg::OUT_DATA_W-1:0]      m_tdata
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [eimt_pkg::WORD_W-1:0] mem [CAPACITY];

	logic                          accept;
	logic                          do_issue;
	logic                          do_clear;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              hint_q;
	logic [CNT_W-1:0]              live_q;

	logic                          rd_vld_s1;
	logic [IDX_W-1:0]              rd_idx_s1;
	logic [eimt_pkg::WORD_W-1:0]   rd_word_s1;

	logic                          kind_q;
	logic                          full_q;
	logic [eimt_pkg::POS_W-1:0]    start_q;
	logic [eimt_pkg::POS_W-1:0]    end_q;
	logic [eimt_pkg::PRICE_W-1:0]  price_q;
	logic [eimt_pkg::POS_W-1:0]    pos_q;

	logic                          found_q;
	logic signed [eimt_pkg::KEY_W-1:0] best_q;

	logic                          out_valid_q;
	logic [eimt_pkg::OUT_W-1:0]    best_price_q;
	logic                          none_active_q;
	logic                          table_full_q;

	logic                          slot_vld;
	logic [eimt_pkg::POS_W-1:0]    slot_exp;
	logic signed [eimt_pkg::KEY_W-1:0] slot_key;
	logic                          free_hit;
	logic                          expired;
	logic                          evict;
	logic                          take_best;
	logic [eimt_pkg::KEY_W-1:0]    new_key;

	logic                          wr_en;
	logic [IDX_W-1:0]              wr_idx;
	logic [eimt_pkg::WORD_W-1:0]   wr_word;

	logic signed [eimt_pkg::SUM_W-1:0] sum;
	logic [eimt_pkg::OUT_W-1:0]    sat_sum;
	logic                          out_free;

	assign accept   = cmd.take & s_tvalid;
	assign do_issue = cmd.issue & (cnt_q != CAP_CNT);
	assign do_clear = cmd.clear_wr & (cnt_q != CAP_CNT);

	// read data fields
	assign slot_vld  = rd_word_s1[eimt_pkg::WORD_W-1];
	assign slot_exp  = rd_word_s1[eimt_pkg::KEY_W +: eimt_pkg::POS_W];
	assign slot_key  = $signed(rd_word_s1[eimt_pkg::KEY_W-1:0]);
	assign expired   = slot_exp < pos_q;
	assign free_hit  = cmd.add_run & rd_vld_s1 & ~slot_vld;
	assign evict     = cmd.tick_run & rd_vld_s1 & slot_vld & expired;
	assign take_best = cmd.tick_run & rd_vld_s1 & slot_vld & ~expired &
	                   (~found_q | (slot_key > best_q));
	assign new_key   = eimt_pkg::KEY_W'(price_q) - eimt_pkg::KEY_W'(start_q);

	// write port: clearing sweep, add fill, or invalidate on eviction
	always_comb begin
		wr_en = do_clear | free_hit | evict;
		if (do_clear) begin
			wr_idx  = cnt_q[IDX_W-1:0];
			wr_word = '0;
		end else if (free_hit) begin
			wr_idx  = rd_idx_s1;
			wr_word = {1'b1, end_q, new_key};
		end else begin
			wr_idx  = rd_idx_s1;
			wr_word = {1'b0, rd_word_s1[eimt_pkg::WORD_W-2:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_word;
		end
		if (do_issue) begin
			rd_word_s1 <= mem[cnt_q[IDX_W-1:0]];
			rd_idx_s1  <= cnt_q[IDX_W-1:0];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			hint_q    <= '0;
			live_q    <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= do_issue;
			if (accept) begin
				cnt_q   <= (s_tuser == eimt_pkg::KIND_TICK) ? '0 : hint_q;
				found_q <= 1'b0;
			end else if (do_issue || do_clear) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (free_hit) begin
				live_q <= live_q + CNT_W'(1);
				hint_q <= CNT_W'(rd_idx_s1) + CNT_W'(1);
			end else if (evict) begin
				live_q <= live_q - CNT_W'(1);
				if (CNT_W'(rd_idx_s1) < hint_q) begin
					hint_q <= CNT_W'(rd_idx_s1);
				end
			end
			if (take_best) begin
				found_q <= 1'b1;
			end
		end
	end

	// item and running maximum
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= s_tuser;
			full_q  <= (live_q == CAP_CNT);
			start_q <= s_tdata[eimt_pkg::START_LSB +: eimt_pkg::POS_W];
			end_q   <= s_tdata[eimt_pkg::END_LSB +: eimt_pkg::POS_W];
			price_q <= s_tdata[eimt_pkg::PRICE_LSB +: eimt_pkg::PRICE_W];
			pos_q   <= s_tdata[eimt_pkg::POS_LSB +: eimt_pkg::POS_W];
		end
		if (take_best) begin
			best_q <= slot_key;
		end
	end

	// saturate the best key plus position into the output range
	always_comb begin
		sum = $signed({best_q[eimt_pkg::KEY_W-1], best_q}) +
		      $signed({1'b0, eimt_pkg::KEY_W'(pos_q)});
		if (sum[eimt_pkg::SUM_W-1]) begin
			sat_sum = '0;
		end else if (sum[eimt_pkg::SUM_W-2:eimt_pkg::OUT_W] != '0) begin
			sat_sum = '1;
		end else begin
			sat_sum = sum[eimt_pkg::OUT_W-1:0];
		end
	end

	assign out_free = ~out_valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (kind_q == eimt_pkg::KIND_TICK) begin
				best_price_q  <= found_q ? sat_sum : '0;
				none_active_q <= ~found_q;
				table_full_q  <= 1'b0;
			end else begin
				best_price_q  <= '0;
				none_active_q <= 1'b0;
				table_full_q  <= full_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{eimt_pkg::OUT_PAD_W{1'b0}}, table_full_q, none_active_q,
	                   best_price_q};

	assign stat.cnt_end   = (cnt_q == CAP_CNT);
	assign stat.pipe_busy = rd_vld_s1;
	assign stat.free_hit  = free_hit;
	assign stat.full      = (live_q == CAP_CNT);
	assign stat.out_free  = out_free;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the expiring interval max table. A queue of offer
// and tick transactions feeds a stream driver. Each accepted transaction runs
// through a local copy of the offer table to form the expected quote. A
// monitor compares every returned quote field by field. Both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned TABLE_DEPTH   = 1024;
	localparam int unsigned RANDOM_OFFERS = 558;
	// Slowest legal run: about 580 transactions, each taking at most one full
	// table scan plus the longest sender gap and the longest receiver stall,
	// plus the clearing pass after reset. Allow several times that.
	localparam longint CYCLE_LIMIT = 64'd5_000_000;

	localparam logic [eimt_pkg::POS_W-1:0]   POS_MAX   = '1;
	localparam logic [eimt_pkg::PRICE_W-1:0] PRICE_MAX = '1;
	// best_price ceiling, 2^31 - 1, at the width of the signed sum
	localparam logic signed [eimt_pkg::SUM_W-1:0] PRICE_CEIL =
		$signed({2'b00, {eimt_pkg::OUT_W{1'b1}}});

	// one input transaction; drain_first holds it back until all quotes are in
	typedef struct packed {
		logic                           kind;
		logic [eimt_pkg::POS_W-1:0]     start_pos;
		logic [eimt_pkg::POS_W-1:0]     end_pos;
		logic [eimt_pkg::PRICE_W-1:0]   base_price;
		logic [eimt_pkg::POS_W-1:0]     position;
		logic                           drain_first;
	} offer_t;

	// one result transaction
	typedef struct packed {
		logic [eimt_pkg::OUT_W-1:0] best_price;
		logic                       none_active;
		logic                       table_full;
	} quote_t;

	logic                            clk;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [eimt_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
	logic                            s_tuser  = eimt_pkg::KIND_ADD;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [eimt_pkg::OUT_DATA_W-1:0] m_tdata;

	offer_t offer_stream[$];   // transactions not yet driven
	quote_t pending_quotes[$]; // quotes owed by the block, oldest first
	offer_t cur_offer;         // transaction currently on the slave side
	int     offers_total;
	int     offers_accepted = 0;
	int     mismatches      = 0;
	int     send_gap        = 0;
	int     send_quiet      = 0;
	int     recv_gap        = 0;
	int     recv_quiet      = 0;
	longint cycle_count     = 0;

	// local copy of the offer table
	bit                                slot_used[TABLE_DEPTH];
	logic signed [eimt_pkg::KEY_W-1:0] slot_key[TABLE_DEPTH];
	logic [eimt_pkg::POS_W-1:0]        slot_expiry[TABLE_DEPTH];
	int                                live_slots = 0;

	expiring_interval_max_table #(
		.CAPACITY(TABLE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Append one transaction to the stimulus queue.
	task automatic queue_offer(input offer_t op);
		offer_stream.insert(offer_stream.size(), op);
	endtask

	// Apply one transaction to the local table and return the quote it owes.
	function automatic quote_t predict_quote(input offer_t op);
		quote_t                            q;
		logic signed [eimt_pkg::KEY_W-1:0] top_key;
		logic signed [eimt_pkg::SUM_W-1:0] total;
		bit                                seen;
		bit                                placed;
		q       = '0;
		top_key = '0;
		seen    = 1'b0;
		placed  = 1'b0;
		if (op.kind == eimt_pkg::KIND_ADD) begin
			if (live_slots >= TABLE_DEPTH) begin
				// full table: drop the offer and flag it
				q.table_full = 1'b1;
			end else begin
				// take the lowest free slot
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (!placed && !slot_used[i]) begin
						slot_used[i]   = 1'b1;
						slot_key[i]    = $signed({{(eimt_pkg::KEY_W-eimt_pkg::PRICE_W){1'b0}},
							op.base_price})
							- $signed({{(eimt_pkg::KEY_W-eimt_pkg::POS_W){1'b0}}, op.start_pos});
						slot_expiry[i] = op.end_pos;
						live_slots++;
						placed = 1'b1;
					end
				end
			end
		end else begin
			// evict entries that ended before the position, track the largest key
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (slot_used[i]) begin
					if (slot_expiry[i] < op.position) begin
						slot_used[i] = 1'b0;
						live_slots--;
					end else if (!seen || slot_key[i] > top_key) begin
						top_key = slot_key[i];
						seen    = 1'b1;
					end
				end
			end
			if (!seen) begin
				q.none_active = 1'b1;
			end else begin
				total = $signed({top_key[eimt_pkg::KEY_W-1], top_key})
					+ $signed({{(eimt_pkg::SUM_W-eimt_pkg::POS_W){1'b0}}, op.position});
				// clamp a negative sum to zero and a large one to the ceiling
				if (total < 0) begin
					q.best_price = '0;
				end else if (total > PRICE_CEIL) begin
					q.best_price = '1;
				end else begin
					q.best_price = total[eimt_pkg::OUT_W-1:0];
				end
			end
		end
		return q;
	endfunction

	// Unused fields of each kind carry random bits; the block must ignore them.
	function automatic offer_t add_offer(input logic [eimt_pkg::POS_W-1:0] from,
		input logic [eimt_pkg::POS_W-1:0] upto, input logic [eimt_pkg::PRICE_W-1:0] price);
		offer_t op;
		op.kind        = eimt_pkg::KIND_ADD;
		op.start_pos   = from;
		op.end_pos     = upto;
		op.base_price  = price;
		op.position    = eimt_pkg::POS_W'($urandom);
		op.drain_first = 1'b0;
		return op;
	endfunction

	function automatic offer_t tick_at(input logic [eimt_pkg::POS_W-1:0] pos);
		offer_t op;
		op.kind        = eimt_pkg::KIND_TICK;
		op.start_pos   = eimt_pkg::POS_W'($urandom);
		op.end_pos     = eimt_pkg::POS_W'($urandom);
		op.base_price  = eimt_pkg::PRICE_W'($urandom);
		op.position    = pos;
		op.drain_first = 1'b0;
		return op;
	endfunction

	function automatic offer_t random_offer();
		offer_t op;
		op.kind        = 1'($urandom_range(0, 1));
		op.start_pos   = eimt_pkg::POS_W'($urandom);
		op.end_pos     = eimt_pkg::POS_W'($urandom);
		op.base_price  = eimt_pkg::PRICE_W'($urandom);
		op.position    = eimt_pkg::POS_W'($urandom);
		op.drain_first = 1'b0;
		return op;
	endfunction

	// Idle length: mostly none or short, now and then long; none while quiet.
	function automatic int idle_span(input bit quiet);
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 150);
	endfunction

	task automatic check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Driver: hold a transaction until accepted, then predict its quote and
	// idle for a random gap before launching the next one.
	always @(posedge clk or negedge arst_n) begin : offer_driver
		offer_t                         nxt;
		logic [eimt_pkg::IN_DATA_W-1:0] word;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= eimt_pkg::KIND_ADD;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				pending_quotes.insert(pending_quotes.size(), predict_quote(cur_offer));
				offers_accepted++;
				if (send_quiet > 0)
					send_quiet--;
				else if ($urandom_range(0, 19) == 0)
					send_quiet = $urandom_range(8, 30);
				send_gap = idle_span(send_quiet > 0);
			end
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (offer_stream.size() != 0
				&& !(offer_stream[0].drain_first && pending_quotes.size() != 0)) begin
				nxt       = offer_stream.pop_front();
				cur_offer = nxt;
				word      = '0;
				word[eimt_pkg::START_LSB +: eimt_pkg::POS_W]   = nxt.start_pos;
				word[eimt_pkg::END_LSB +: eimt_pkg::POS_W]     = nxt.end_pos;
				word[eimt_pkg::PRICE_LSB +: eimt_pkg::PRICE_W] = nxt.base_price;
				word[eimt_pkg::POS_LSB +: eimt_pkg::POS_W]     = nxt.position;
				s_tdata  <= word;
				s_tuser  <= nxt.kind;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each quote against the oldest prediction, then stall
	// tready for a random span.
	always @(posedge clk or negedge arst_n) begin : quote_monitor
		quote_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_quotes.size() == 0) begin
					$display("%0t ns: unexpected quote, expected none, actual tdata 0x%0h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = pending_quotes.pop_front();
					check_field("best_price", 64'(want.best_price),
						64'(m_tdata[eimt_pkg::OUT_W-1:0]));
					check_field("none_active", 64'(want.none_active),
						64'(m_tdata[eimt_pkg::OUT_W]));
					check_field("table_full", 64'(want.table_full),
						64'(m_tdata[eimt_pkg::OUT_W+1]));
					check_field("tdata pad", 64'd0,
						64'(m_tdata[eimt_pkg::OUT_DATA_W-1:eimt_pkg::OUT_BITS]));
				end
				if (recv_quiet > 0)
					recv_quiet--;
				else if ($urandom_range(0, 19) == 0)
					recv_quiet = $urandom_range(8, 30);
				recv_gap = idle_span(recv_quiet > 0);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Abort a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		offer_t                       op;
		logic [eimt_pkg::POS_W-1:0]   cursor;
		logic [eimt_pkg::POS_W-1:0]   from;
		logic [eimt_pkg::POS_W-1:0]   span;
		logic [eimt_pkg::PRICE_W-1:0] price;
		int                           roll;

		// Directed part.
		// empty table at both ends of the position range
		queue_offer(tick_at(0));
		queue_offer(tick_at(POS_MAX));
		// most negative key: ticks before its start clamp to zero, the last sums to zero
		queue_offer(add_offer(POS_MAX, POS_MAX, '0));
		queue_offer(tick_at(0));
		queue_offer(tick_at(5));
		queue_offer(tick_at(POS_MAX));
		// end before start: stored, then evicted by the first tick past its end
		queue_offer(add_offer(100, 50, 1000));
		queue_offer(tick_at(40));
		queue_offer(tick_at(51));
		// falling position: the evicted entry stays gone
		queue_offer(tick_at(30));
		// duplicate offers take a slot each and expire together
		queue_offer(add_offer(10, 200, 500));
		queue_offer(add_offer(10, 200, 500));
		queue_offer(tick_at(150));
		queue_offer(tick_at(201));
		// largest key with the largest and the smallest position
		queue_offer(add_offer(0, POS_MAX, PRICE_MAX));
		queue_offer(tick_at(POS_MAX));
		queue_offer(tick_at(0));
		queue_offer(add_offer(POS_MAX, 0, PRICE_MAX));
		queue_offer(tick_at(0));
		queue_offer(tick_at(1));
		queue_offer(random_offer());
		queue_offer(random_offer());

		// Random part: offers that start near a rising tick cursor, ticks at the
		// cursor, and some noise transactions mixed in.
		cursor = eimt_pkg::POS_W'($urandom);
		for (int n = 0; n < RANDOM_OFFERS; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				op = random_offer();
			end else if (roll < 62) begin
				from  = cursor + eimt_pkg::POS_W'($urandom_range(0, 60));
				span  = ($urandom_range(0, 9) == 0) ? eimt_pkg::POS_W'($urandom)
					: eimt_pkg::POS_W'($urandom_range(0, 400));
				price = ($urandom_range(0, 9) < 7)
					? eimt_pkg::PRICE_W'($urandom_range(0, 1 << 20))
					: eimt_pkg::PRICE_W'($urandom);
				op    = add_offer(from, from + span, price);
			end else begin
				cursor = cursor + eimt_pkg::POS_W'($urandom_range(0, 30));
				op     = tick_at(cursor);
			end
			op.drain_first = (n % 150 == 75);
			queue_offer(op);
		end
		offers_total = offer_stream.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every transaction and every quote, then let a full scan pass.
		while (offers_accepted < offers_total)
			@(posedge clk);
		while (pending_quotes.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 16) @(posedge clk);

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
